### src/pdp_pkg.sv
// Shared constants, register indexes and saturating add for the projection pipeline.
package pdp_pkg;

  // Register index width and register indexes of the configuration port.
  localparam int RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_FOCAL   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_CENTRE  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_K1      = 3'd2;
  localparam logic [RegIdxW-1:0] REG_K2      = 3'd3;
  localparam logic [RegIdxW-1:0] REG_K3      = 3'd4;
  localparam logic [RegIdxW-1:0] REG_P1      = 3'd5;
  localparam logic [RegIdxW-1:0] REG_P2      = 3'd6;

  // Q32.32 limits and the value one.
  localparam logic signed [63:0] SMAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

  // Latencies of the divider and of the multiplier.
  localparam int DivLat = 66;
  localparam int MulLat = 4;

  // Saturating add: result in bits 63:0, clamp flag in bit 64.
  function automatic logic [64:0] add_sat(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [64:0] lim;
    s   = {a[63], a} + {b[63], b};
    lim = {1'b0, SMAX};
    if (s > lim) begin
      return {1'b1, SMAX};
    end else if (s < -lim) begin
      return {1'b1, -SMAX};
    end else begin
      return {1'b0, s[63:0]};
    end
  endfunction

endpackage

### src/pdp_ifs.sv
// Handshake interfaces for the point and pixel channels.
interface pdp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source(output valid, output point_x, output point_y, output point_z, input ready);
  modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface pdp_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_u;
  logic signed [31:0] pixel_v;
  logic               valid_res;
  logic               saturated;
  modport source(output valid, output pixel_u, output pixel_v, output valid_res,
                 output saturated, input ready);
  modport sink(input valid, input pixel_u, input pixel_v, input valid_res,
               input saturated, output ready);
endinterface

### src/pinhole_distortion_projection.sv
// Top level: pinhole projection with radial and tangential distortion.
//
//   channel  | direction | payload
//   points   | in        | point_x, point_y, point_z (Q16.16)
//   pixels   | out       | pixel_u, pixel_v (Q16.16), valid_res, saturated
//   cfg_*    | in        | write enable, register index, 64-bit data
//
// One item per cycle while no result waits at the output; an item passes 66 divider
// stages (64 steps plus entry and exit) and 29 stages of multipliers and adders
// before its result is loaded into the output register.
// Reset clears the register file and the valid bits of all stages.
// When a result waits at the output the whole pipeline holds, nothing moves.
module pinhole_distortion_projection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pdp_pkg::RegIdxW-1:0]   cfg_index,
  input  logic [63:0]                   cfg_data,
  pdp_point_if.sink                     points,
  pdp_pixel_if.source                   pixels
);
  import pdp_pkg::*;

  localparam int S0 = DivLat;      // normalised coordinates ready
  localparam int NS = S0 + 29;     // last internal stage

  // Configuration registers.
  logic [63:0]        focal, centre;
  logic signed [31:0] k1, k2, k3, p1, p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal  <= '0;
      centre <= '0;
      k1 <= '0; k2 <= '0; k3 <= '0; p1 <= '0; p2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL:  focal  <= cfg_data;
        REG_CENTRE: centre <= cfg_data;
        REG_K1:     k1 <= cfg_data[31:0];
        REG_K2:     k2 <= cfg_data[31:0];
        REG_K3:     k3 <= cfg_data[31:0];
        REG_P1:     p1 <= cfg_data[31:0];
        REG_P2:     p2 <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Q4.28 coefficients moved to Q32.32 so every product shifts by 32.
  logic signed [63:0] k1s, k2s, k3s, p1s, p2s, fxs, fys, cxs, cys;
  assign k1s = {{28{k1[31]}}, k1, 4'b0};
  assign k2s = {{28{k2[31]}}, k2, 4'b0};
  assign k3s = {{28{k3[31]}}, k3, 4'b0};
  assign p1s = {{28{p1[31]}}, p1, 4'b0};
  assign p2s = {{28{p2[31]}}, p2, 4'b0};
  assign fxs = {32'b0, focal[31:0]};
  assign fys = {32'b0, focal[63:32]};
  assign cxs = {32'b0, centre[31:0]};
  assign cys = {32'b0, centre[63:32]};

  // Global advance: the pipeline moves unless a result waits at the output.
  logic en;
  assign en           = !pixels.valid || pixels.ready;
  assign points.ready = en;

  // Valid, positive-depth and saturation bits travel with each item.
  logic [NS:1] vld, zp, sl;
  logic [NS:1] sfl;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:1], points.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zp <= {zp[NS-1:1], points.point_z > 32'sd0};
      sl <= {sl[NS-1:1] | sfl[NS-1:1], 1'b0};
    end
  end

  // Division by depth.
  logic signed [63:0] xq, yq;
  logic               xq_s, yq_s;
  pdp_div u_div_x (.clk, .en, .num(points.point_x), .den(points.point_z), .quo(xq), .sat(xq_s));
  pdp_div u_div_y (.clk, .en, .num(points.point_y), .den(points.point_z), .quo(yq), .sat(yq_s));

  // Squares and cross term.
  logic signed [63:0] x2, y2, xy;
  logic               x2_s, y2_s, xy_s;
  pdp_mul u_mul_x2 (.clk, .en, .a(xq), .b(xq), .p(x2), .sat(x2_s));
  pdp_mul u_mul_y2 (.clk, .en, .a(yq), .b(yq), .p(y2), .sat(y2_s));
  pdp_mul u_mul_xy (.clk, .en, .a(xq), .b(yq), .p(xy), .sat(xy_s));

  // First row of sums: 2xy, r^2, 2x^2, 2y^2.
  logic signed [63:0] xy2, r2, xx2, yy2, tx, ty;
  logic               xy2_s, r2_s, xx2_s, yy2_s, tx_s, ty_s;
  always_ff @(posedge clk) begin
    if (en) begin
      {xy2_s, xy2} <= add_sat(xy, xy);
      {r2_s, r2}   <= add_sat(x2, y2);
      {xx2_s, xx2} <= add_sat(x2, x2);
      {yy2_s, yy2} <= add_sat(y2, y2);
    end
  end

  // Tangential arguments r^2 + 2x^2 and r^2 + 2y^2.
  always_ff @(posedge clk) begin
    if (en) begin
      {tx_s, tx} <= add_sat(r2, xx2);
      {ty_s, ty} <= add_sat(r2, yy2);
    end
  end

  // Powers of r^2 and coefficient products.
  logic signed [63:0] r4, r6, kr1, kr2, kr3, mp1x, mp2y, mp2x, mp1y;
  logic               r4_s, r6_s, kr1_s, kr2_s, kr3_s, mp1x_s, mp2y_s, mp2x_s, mp1y_s;
  logic signed [63:0] r2_dl [4];
  pdp_mul u_mul_r4   (.clk, .en, .a(r2),  .b(r2),  .p(r4),   .sat(r4_s));
  pdp_mul u_mul_kr1  (.clk, .en, .a(k1s), .b(r2),  .p(kr1),  .sat(kr1_s));
  pdp_mul u_mul_mp1x (.clk, .en, .a(p1s), .b(xy2), .p(mp1x), .sat(mp1x_s));
  pdp_mul u_mul_mp2y (.clk, .en, .a(p2s), .b(xy2), .p(mp2y), .sat(mp2y_s));
  pdp_mul u_mul_mp2x (.clk, .en, .a(p2s), .b(tx),  .p(mp2x), .sat(mp2x_s));
  pdp_mul u_mul_mp1y (.clk, .en, .a(p1s), .b(ty),  .p(mp1y), .sat(mp1y_s));
  pdp_mul u_mul_r6   (.clk, .en, .a(r4),  .b(r2_dl[3]), .p(r6), .sat(r6_s));
  pdp_mul u_mul_kr2  (.clk, .en, .a(k2s), .b(r4),  .p(kr2),  .sat(kr2_s));
  pdp_mul u_mul_kr3  (.clk, .en, .a(k3s), .b(r6),  .p(kr3),  .sat(kr3_s));

  // Radial factor, summed in the order 1 + k1 r^2, + k2 r^4, + k3 r^6.
  logic signed [63:0] rad1, rad2, rad3;
  logic               rad1_s, rad2_s, rad3_s;
  logic signed [63:0] rad1_dl [3];
  logic signed [63:0] rad2_dl [3];
  always_ff @(posedge clk) begin
    if (en) begin
      {rad1_s, rad1} <= add_sat(ONE_Q32, kr1);
      {rad2_s, rad2} <= add_sat(rad1_dl[2], kr2);
      {rad3_s, rad3} <= add_sat(rad2_dl[2], kr3);
    end
  end

  // Distorted coordinates.
  logic signed [63:0] x_dl [18];
  logic signed [63:0] y_dl [18];
  logic signed [63:0] xm, ym, xd1, yd1, xd, yd;
  logic               xm_s, ym_s, xd1_s, yd1_s, xd_s, yd_s;
  logic signed [63:0] mp1x_dl [13];
  logic signed [63:0] mp2y_dl [13];
  logic signed [63:0] mp2x_dl [13];
  logic signed [63:0] mp1y_dl [13];
  pdp_mul u_mul_xm (.clk, .en, .a(x_dl[17]), .b(rad3), .p(xm), .sat(xm_s));
  pdp_mul u_mul_ym (.clk, .en, .a(y_dl[17]), .b(rad3), .p(ym), .sat(ym_s));

  always_ff @(posedge clk) begin
    if (en) begin
      {xd1_s, xd1} <= add_sat(xm, mp1x_dl[12]);
      {yd1_s, yd1} <= add_sat(ym, mp2y_dl[12]);
      {xd_s, xd}   <= add_sat(xd1, mp2x_dl[12]);
      {yd_s, yd}   <= add_sat(yd1, mp1y_dl[12]);
    end
  end

  // Delay lines that line operands up with their partners.
  always_ff @(posedge clk) begin
    if (en) begin
      r2_dl[0]   <= r2;
      rad1_dl[0] <= rad1;
      rad2_dl[0] <= rad2;
      x_dl[0]    <= xq;
      y_dl[0]    <= yq;
      mp1x_dl[0] <= mp1x;
      mp2y_dl[0] <= mp2y;
      mp2x_dl[0] <= mp2x;
      mp1y_dl[0] <= mp1y;
      for (int j = 1; j < 4; j++) r2_dl[j] <= r2_dl[j-1];
      for (int j = 1; j < 3; j++) begin
        rad1_dl[j] <= rad1_dl[j-1];
        rad2_dl[j] <= rad2_dl[j-1];
      end
      for (int j = 1; j < 18; j++) begin
        x_dl[j] <= x_dl[j-1];
        y_dl[j] <= y_dl[j-1];
      end
      for (int j = 1; j < 13; j++) begin
        mp1x_dl[j] <= mp1x_dl[j-1];
        mp2y_dl[j] <= mp2y_dl[j-1];
        mp2x_dl[j] <= mp2x_dl[j-1];
        mp1y_dl[j] <= mp1y_dl[j-1];
      end
    end
  end

  // Focal scaling and principal offset.
  logic signed [63:0] pu, pv, pa, pb;
  logic               pu_s, pv_s, pa_s, pb_s;
  pdp_mul u_mul_pu (.clk, .en, .a(fxs), .b(xd), .p(pu), .sat(pu_s));
  pdp_mul u_mul_pv (.clk, .en, .a(fys), .b(yd), .p(pv), .sat(pv_s));

  always_ff @(posedge clk) begin
    if (en) begin
      {pa_s, pa} <= add_sat(pu, cxs);
      {pb_s, pb} <= add_sat(pv, cys);
    end
  end

  // Clamp flags gathered at the stage where each result is registered.
  always_comb begin
    sfl          = '0;
    sfl[S0]      = xq_s | yq_s;
    sfl[S0+4]    = x2_s | y2_s | xy_s;
    sfl[S0+5]    = xy2_s | r2_s | xx2_s | yy2_s;
    sfl[S0+6]    = tx_s | ty_s;
    sfl[S0+9]    = r4_s | kr1_s | mp1x_s | mp2y_s;
    sfl[S0+10]   = mp2x_s | mp1y_s | rad1_s;
    sfl[S0+13]   = r6_s | kr2_s;
    sfl[S0+14]   = rad2_s;
    sfl[S0+17]   = kr3_s;
    sfl[S0+18]   = rad3_s;
    sfl[S0+22]   = xm_s | ym_s;
    sfl[S0+23]   = xd1_s | yd1_s;
    sfl[S0+24]   = xd_s | yd_s;
    sfl[S0+28]   = pu_s | pv_s;
    sfl[S0+29]   = pa_s | pb_s;
  end

  // Final clamp to the Q16.16 range.
  logic signed [31:0] cu, cv;
  logic               cu_s, cv_s;
  always_comb begin
    cu   = pa[31:0];
    cu_s = 1'b0;
    if (pa > 64'sh7FFF_FFFF) begin
      cu = 32'sh7FFF_FFFF; cu_s = 1'b1;
    end else if (pa < -64'sh8000_0000) begin
      cu = 32'sh8000_0000; cu_s = 1'b1;
    end
    cv   = pb[31:0];
    cv_s = 1'b0;
    if (pb > 64'sh7FFF_FFFF) begin
      cv = 32'sh7FFF_FFFF; cv_s = 1'b1;
    end else if (pb < -64'sh8000_0000) begin
      cv = 32'sh8000_0000; cv_s = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (en) begin
      pixels.valid <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zp[NS]) begin
        pixels.pixel_u   <= cu;
        pixels.pixel_v   <= cv;
        pixels.valid_res <= 1'b1;
        pixels.saturated <= sl[NS] | sfl[NS] | cu_s | cv_s;
      end else begin
        pixels.pixel_u   <= '0;
        pixels.pixel_v   <= '0;
        pixels.valid_res <= 1'b0;
        pixels.saturated <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // A point behind the camera yields an all-zero result.
  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && !pixels.valid_res |->
      pixels.pixel_u == 32'sd0 && pixels.pixel_v == 32'sd0 && !pixels.saturated)
    else $error("point behind camera gave a non-zero result");

  // Saturation is only reported for a point in front of the camera.
  a_sat_valid: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && pixels.saturated |-> pixels.valid_res)
    else $error("saturation flagged on an invalid point");

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !pixels.valid)
    else $error("result offered straight after reset");
`endif

endmodule

### src/pdp_mul.sv
// Pipelined 64 by 64 signed multiplier, rounded shift by 32 and saturation.
module pdp_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p,
  output logic               sat
);
  import pdp_pkg::*;

  logic [63:0]  ma, mb;
  logic         ng1, ng2, ng3;
  logic [63:0]  p00, p01, p10, p11;
  logic [127:0] sum;
  logic [63:0]  rl;

  // Stage one: magnitudes and sign of the product.
  always_ff @(posedge clk) begin
    if (en) begin
      ma  <= a[63] ? 64'(-a) : 64'(a);
      mb  <= b[63] ? 64'(-b) : 64'(b);
      ng1 <= a[63] ^ b[63];
    end
  end

  // Stage two: four 32 by 32 partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= {32'b0, ma[31:0]}  * {32'b0, mb[31:0]};
      p01 <= {32'b0, ma[31:0]}  * {32'b0, mb[63:32]};
      p10 <= {32'b0, ma[63:32]} * {32'b0, mb[31:0]};
      p11 <= {32'b0, ma[63:32]} * {32'b0, mb[63:32]};
      ng2 <= ng1;
    end
  end

  // Stage three: full product plus the rounding half.
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= {p11, 64'b0} + {32'b0, p01, 32'b0} + {32'b0, p10, 32'b0} + {64'b0, p00}
             + 128'h8000_0000;
      ng3 <= ng2;
    end
  end

  // Stage four: take the middle bits, clamp, restore the sign.
  always_comb begin
    rl = sum[95:32];
    if (sum[127:96] != 32'b0 || sum[95]) begin
      rl = 64'(SMAX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= (sum[127:96] != 32'b0) || sum[95];
      p   <= ng3 ? -$signed(rl) : $signed(rl);
    end
  end

endmodule

### src/pdp_div.sv
// Pipelined restoring divider giving round(|num| * 2^32 / den) with the sign of num.
module pdp_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [63:0] quo,
  output logic               sat
);
  import pdp_pkg::*;

  localparam int Steps = 64;

  logic [31:0] rem [Steps+1];
  logic [63:0] nq  [Steps+1];
  logic [31:0] dv  [Steps+1];
  logic        ng  [Steps+1];
  logic [31:0] mag;
  logic [63:0] q;

  assign mag = num[31] ? 32'(-num) : 32'(num);

  // Entry stage: shifted magnitude plus half the divisor for rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= 32'b0;
      nq[0]  <= {mag, 32'b0} + {33'b0, den[31:1]};
      dv[0]  <= den;
      ng[0]  <= num[31];
    end
  end

  // One quotient bit per stage; dividend bits shift out as quotient bits shift in.
  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [32:0] rs;
    logic [32:0] diff;
    logic        ge;
    assign rs   = {rem[i], nq[i][63]};
    assign diff = rs - {1'b0, dv[i]};
    assign ge   = rs >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[31:0] : rs[31:0];
        nq[i+1]  <= {nq[i][62:0], ge};
        dv[i+1]  <= dv[i];
        ng[i+1]  <= ng[i];
      end
    end
  end

  // Exit stage: clamp and apply the sign.
  always_comb begin
    q = nq[Steps];
    if (q[63]) begin
      q = 64'(SMAX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= nq[Steps][63];
      quo <= ng[Steps] ? -$signed(q) : $signed(q);
    end
  end

endmodule
